>>> rtl/svmm_pkg.sv
`timescale 1ns / 1ps

package svmm_pkg;

  localparam int IN_W            = 16;
  localparam int DUTY_W          = 13;
  localparam int DUTY_LOG2       = 12;
  localparam int DUTY_FULL_SCALE = 1 << DUTY_LOG2;
  localparam int QW              = DUTY_LOG2 + 1;
  localparam int NPH             = 3;

  localparam int SQRT3_HALF_Q16  = 56756;
  localparam int VBUS_DEFAULT    = 256;

  // phase voltages, doubled injected phases, duty numerator
  localparam int PW  = 34;
  localparam int P2W = 36;
  localparam int NW  = 38;
  localparam int RSH = 19 - DUTY_LOG2;
  localparam int MW  = NW - 1 - RSH;

  typedef logic [MW-1:0]     rem_t;
  typedef logic [IN_W-1:0]   vbus_t;
  typedef logic [DUTY_W-1:0] duty_t;

  typedef struct packed {
    logic           valid;
    logic [NPH-1:0] sat;
  } div_ctl_t;

endpackage

>>> rtl/svmm_div.sv
`timescale 1ns / 1ps

module svmm_div (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  svmm_pkg::div_ctl_t                   in_ctl,
  input  svmm_pkg::rem_t [svmm_pkg::NPH-1:0]   in_rem,
  input  svmm_pkg::vbus_t                      in_div,
  output logic                                 out_valid,
  output svmm_pkg::duty_t [svmm_pkg::NPH-1:0]  out_duty
);
  import svmm_pkg::*;

  logic [QW:0]             valid_r;
  rem_t [NPH-1:0]          rem_r [QW+1];
  logic [NPH-1:0][QW-1:0]  q_r   [QW+1];
  vbus_t                   div_r [QW+1];
  logic [NPH-1:0]          sat_r [QW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= {valid_r[QW-1:0], in_ctl.valid};
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= in_rem;
    q_r[0]   <= '0;
    div_r[0] <= in_div;
    sat_r[0] <= in_ctl.sat;
  end

  // one quotient bit per stage, MSB first
  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int BIT = QW - 1 - k;

    rem_t [NPH-1:0]         rem_nxt;
    logic [NPH-1:0][QW-1:0] q_nxt;

    always_comb begin
      rem_t       sh;
      logic [MW:0] diff;
      sh = MW'(div_r[k]) << BIT;
      for (int p = 0; p < NPH; p++) begin
        diff       = {1'b0, rem_r[k][p]} - {1'b0, sh};
        q_nxt[p]   = q_r[k][p];
        q_nxt[p][BIT] = ~diff[MW];
        rem_nxt[p] = diff[MW] ? rem_r[k][p] : diff[MW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k+1] <= rem_nxt;
      q_r[k+1]   <= q_nxt;
      div_r[k+1] <= div_r[k];
      sat_r[k+1] <= sat_r[k];
    end
  end

  assign out_valid = valid_r[QW];

  always_comb begin
    for (int p = 0; p < NPH; p++) begin
      out_duty[p] = sat_r[QW][p] ? DUTY_W'(DUTY_FULL_SCALE) : DUTY_W'(q_r[QW][p]);
    end
  end

endmodule

>>> rtl/svpwm_min_max_injection.sv
// out_valid follows start through the front stages, divider and output register.
// Throughput: one word per cycle; busy is tied low, so start is taken every cycle.
// The duty divide is a 13-stage restoring divider, one quotient bit per stage,
// three phases side by side, after six stages of transform and offset math.
// Reset (rst_n low, synchronous) clears only the valid pipe; results are not stallable.
`timescale 1ns / 1ps

module svpwm_min_max_injection (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [15:0]            in_v_alpha,
  input  logic signed [15:0]            in_v_beta,
  input  logic [15:0]                   in_bus_voltage,
  output logic                          out_valid,
  output svmm_pkg::duty_t               out_duty_phase_a,
  output svmm_pkg::duty_t               out_duty_phase_b,
  output svmm_pkg::duty_t               out_duty_phase_c
);
  import svmm_pkg::*;

  localparam logic signed [PW-1:0] K_SQRT3 = PW'(SQRT3_HALF_Q16);

  logic [6:1] valid_r;

  logic signed [IN_W-1:0] va1_r, vb1_r;
  vbus_t                  vbus1_r, vbus1_nxt;
  logic signed [IN_W-1:0] va2_r;
  logic signed [PW-1:0]   vbk2_r, vbk2_nxt;
  vbus_t                  vbus2_r, vbus3_r, vbus4_r, vbus5_r, vbus6_r;
  logic signed [PW-1:0]   ph3_r [NPH];
  logic signed [PW-1:0]   ph3_nxt [NPH];
  logic signed [PW-1:0]   ph4_r [NPH];
  logic signed [PW:0]     sum4_r, sum4_nxt;
  logic signed [P2W-1:0]  p2_5_r [NPH];
  logic signed [P2W-1:0]  p2_5_nxt [NPH];
  logic signed [NW-1:0]   n6_r [NPH];
  logic signed [NW-1:0]   n6_nxt [NPH];
  rem_t                   vlim6_r, vlim6_nxt;

  div_ctl_t                 div_ctl;
  rem_t [NPH-1:0]           div_rem;
  logic                     div_valid;
  duty_t [NPH-1:0]          div_duty;

  logic                     out_valid_r;
  duty_t [NPH-1:0]          duty_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      valid_r     <= {valid_r[5:1], start};
      out_valid_r <= div_valid;
    end
  end

  // stage 1: capture, zero bus voltage -> 1 V
  assign vbus1_nxt = (in_bus_voltage == '0) ? IN_W'(VBUS_DEFAULT) : in_bus_voltage;

  always_ff @(posedge clk) begin
    va1_r   <= in_v_alpha;
    vb1_r   <= in_v_beta;
    vbus1_r <= vbus1_nxt;
  end

  // stage 2: beta * sqrt(3)/2
  always_comb begin
    logic signed [PW-1:0] vb_x;
    vb_x     = PW'(vb1_r);
    vbk2_nxt = vb_x * K_SQRT3;
  end

  always_ff @(posedge clk) begin
    va2_r   <= va1_r;
    vbk2_r  <= vbk2_nxt;
    vbus2_r <= vbus1_r;
  end

  // stage 3: inverse Clarke, units of 2^-16 LSB
  always_comb begin
    logic signed [PW-1:0] va_x;
    va_x       = PW'(va2_r);
    ph3_nxt[0] = va_x <<< 16;
    ph3_nxt[1] = -(va_x <<< 15) + vbk2_r;
    ph3_nxt[2] = -(va_x <<< 15) - vbk2_r;
  end

  always_ff @(posedge clk) begin
    ph3_r   <= ph3_nxt;
    vbus3_r <= vbus2_r;
  end

  // stage 4: max + min
  always_comb begin
    logic signed [PW-1:0] hi, lo;
    hi = ph3_r[0];
    lo = ph3_r[0];
    for (int p = 1; p < NPH; p++) begin
      if (ph3_r[p] > hi) hi = ph3_r[p];
      if (ph3_r[p] < lo) lo = ph3_r[p];
    end
    sum4_nxt = (PW+1)'(hi) + (PW+1)'(lo);
  end

  always_ff @(posedge clk) begin
    ph4_r   <= ph3_r;
    sum4_r  <= sum4_nxt;
    vbus4_r <= vbus3_r;
  end

  // stage 5: doubled injected phase
  always_comb begin
    for (int p = 0; p < NPH; p++) begin
      p2_5_nxt[p] = (P2W'(ph4_r[p]) <<< 1) - P2W'(sum4_r);
    end
  end

  always_ff @(posedge clk) begin
    p2_5_r  <= p2_5_nxt;
    vbus5_r <= vbus4_r;
  end

  // stage 6: rounded duty numerator, saturation limit
  always_comb begin
    logic signed [NW-1:0] vx, vterm;
    vx    = $signed({{(NW-IN_W){1'b0}}, vbus5_r});
    vterm = (vx <<< 18) + (vx <<< (18 - DUTY_LOG2));
    for (int p = 0; p < NPH; p++) begin
      n6_nxt[p] = (NW'(p2_5_r[p]) <<< 1) + vterm;
    end
    vlim6_nxt = (MW'(vbus5_r) << DUTY_LOG2) + MW'(vbus5_r);
  end

  always_ff @(posedge clk) begin
    n6_r    <= n6_nxt;
    vlim6_r <= vlim6_nxt;
    vbus6_r <= vbus5_r;
  end

  // negative clamps to zero, limit check feeds the divider
  always_comb begin
    div_ctl.valid = valid_r[6];
    for (int p = 0; p < NPH; p++) begin
      div_rem[p]     = n6_r[p][NW-1] ? '0 : n6_r[p][RSH +: MW];
      div_ctl.sat[p] = (div_rem[p] >= vlim6_r);
    end
  end

  svmm_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ctl    (div_ctl),
    .in_rem    (div_rem),
    .in_div    (vbus6_r),
    .out_valid (div_valid),
    .out_duty  (div_duty)
  );

  always_ff @(posedge clk) begin
    duty_r <= div_duty;
  end

  assign out_valid        = out_valid_r;
  assign out_duty_phase_a = duty_r[0];
  assign out_duty_phase_b = duty_r[1];
  assign out_duty_phase_c = duty_r[2];

endmodule

>>> verif/svpwm_min_max_injection_test.sv
`timescale 1ns / 1ps

module svpwm_min_max_injection_test;
  import svmm_pkg::*;

  typedef struct {
    duty_t a;
    duty_t b;
    duty_t c;
  } duty_set_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic signed [15:0] in_v_alpha;
  logic signed [15:0] in_v_beta;
  logic [15:0]        in_bus_voltage;
  logic               out_valid;
  duty_t              out_duty_phase_a;
  duty_t              out_duty_phase_b;
  duty_t              out_duty_phase_c;

  duty_set_t pending_duties[$];
  duty_set_t oldest_duty;
  int        error_count = 0;
  bit        idle_on = 1'b1;

  svpwm_min_max_injection dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_v_alpha       (in_v_alpha),
    .in_v_beta        (in_v_beta),
    .in_bus_voltage   (in_bus_voltage),
    .out_valid        (out_valid),
    .out_duty_phase_a (out_duty_phase_a),
    .out_duty_phase_b (out_duty_phase_b),
    .out_duty_phase_c (out_duty_phase_c)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 150000);
    $display("svpwm_min_max_injection_test: done, errors");
    $finish;
  end

  // duty = round(FS * (p2 + 2^17 * vbus) / (2^18 * vbus)), ties up, clamped
  function automatic duty_t duty_of(input longint p2, input longint vbus);
    longint num;
    longint den;
    longint q;
    num = longint'(DUTY_FULL_SCALE) * p2 + longint'(DUTY_FULL_SCALE) * 131072 * vbus;
    den = 262144 * vbus;
    if (num < 0) return '0;
    q = (num * 2 + den) / (den * 2);
    if (q > DUTY_FULL_SCALE) q = DUTY_FULL_SCALE;
    return duty_t'(q);
  endfunction

  function automatic duty_set_t svm_duties(input logic signed [15:0] va_in,
                                           input logic signed [15:0] vb_in,
                                           input logic [15:0] vbus_in);
    longint    va;
    longint    vb;
    longint    vbus;
    longint    pa;
    longint    pb;
    longint    pc;
    longint    hi;
    longint    lo;
    longint    sum;
    duty_set_t d;
    va   = va_in;
    vb   = vb_in;
    vbus = vbus_in;
    if (vbus == 0) vbus = VBUS_DEFAULT;
    pa = va * 65536;
    pb = -va * 32768 + vb * SQRT3_HALF_Q16;
    pc = -va * 32768 - vb * SQRT3_HALF_Q16;
    hi = pa;
    if (pb > hi) hi = pb;
    if (pc > hi) hi = pc;
    lo = pa;
    if (pb < lo) lo = pb;
    if (pc < lo) lo = pc;
    sum = hi + lo;
    d.a = duty_of(2 * pa - sum, vbus);
    d.b = duty_of(2 * pb - sum, vbus);
    d.c = duty_of(2 * pc - sum, vbus);
    return d;
  endfunction

  task automatic send_word(input logic signed [15:0] va, input logic signed [15:0] vb,
                           input logic [15:0] vbus);
    bit taken;
    taken = 1'b0;
    while (idle_on && $urandom_range(99) < 24) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start          <= 1'b1;
    in_v_alpha     <= va;
    in_v_beta      <= vb;
    in_bus_voltage <= vbus;
    while (!taken) begin
      @(negedge clk);
      taken = (busy === 1'b0);
      @(posedge clk);
    end
    pending_duties.push_back(svm_duties(va, vb, vbus));
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    wait (pending_duties.size() == 0);
    @(posedge clk);
  endtask

  // output check, mid-cycle so it never races the edge
  always @(negedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (pending_duties.size() == 0) begin
        $error("unexpected result word: a=%0d b=%0d c=%0d",
               out_duty_phase_a, out_duty_phase_b, out_duty_phase_c);
        error_count++;
      end else begin
        oldest_duty = pending_duties.pop_front();
        if (out_duty_phase_a !== oldest_duty.a) begin
          $error("duty_phase_a: expected %0d, got %0d", oldest_duty.a, out_duty_phase_a);
          error_count++;
        end
        if (out_duty_phase_b !== oldest_duty.b) begin
          $error("duty_phase_b: expected %0d, got %0d", oldest_duty.b, out_duty_phase_b);
          error_count++;
        end
        if (out_duty_phase_c !== oldest_duty.c) begin
          $error("duty_phase_c: expected %0d, got %0d", oldest_duty.c, out_duty_phase_c);
          error_count++;
        end
      end
    end
  end

  task automatic test_directed();
    send_word(16'sd0, 16'sd0, 16'd0);            // zero bus -> 1 V
    send_word(16'sd0, 16'sd0, 16'd65535);
    send_word(16'sd32767, 16'sd0, 16'd1);        // saturate high / low
    send_word(-16'sd32768, 16'sd0, 16'd1);
    send_word(16'sd0, 16'sd32767, 16'd1);
    send_word(16'sd0, -16'sd32768, 16'd65535);
    send_word(16'sd32767, 16'sd32767, 16'd65535);
    send_word(-16'sd32768, -16'sd32768, 16'd0);
    send_word(16'sd32767, -16'sd32768, 16'd0);
    send_word(-16'sd32768, 16'sd32767, 16'd32768);
    send_word(16'sd1, 16'sd0, 16'd3072);         // exact half, rounds up
    send_word(-16'sd1, 16'sd0, 16'd3072);
    send_word(16'sd256, 16'sd0, 16'd0);
    send_word(16'sd0, 16'sd256, 16'd0);
    send_word(16'sd10000, 16'sd5773, 16'd20000);
    send_word(-16'sd12000, 16'sd9000, 16'd24000);
    send_word(16'sd1, -16'sd1, 16'd1);
    send_word(16'sd21845, 16'sd12612, 16'd32768);
    wait_drained();
  endtask

  task automatic test_random_full(input int n);
    logic [15:0] vbus;
    repeat (n) begin
      vbus = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom);
      send_word(16'($urandom), 16'($urandom), vbus);
    end
  endtask

  // commands scaled to the bus, mostly linear range with some overmodulation
  task automatic test_random_in_range(input int n);
    int          vbus;
    int          lim;
    logic [15:0] vbus_word;
    repeat (n) begin
      vbus = $urandom_range(65535, 1);
      lim  = vbus * $urandom_range(75, 20) / 100;
      if (lim > 32767) lim = 32767;
      vbus_word = 16'(vbus);
      send_word(16'($urandom_range(2 * lim) - lim), 16'($urandom_range(2 * lim) - lim),
                vbus_word);
    end
  endtask

  task automatic test_pause_drain();
    test_random_in_range(60);
    wait_drained();
    test_random_full(60);
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    test_random_in_range(140);
    test_random_full(140);
    idle_on = 1'b1;
  endtask

  initial begin
    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_v_alpha     <= '0;
    in_v_beta      <= '0;
    in_bus_voltage <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_full(250);
    test_random_in_range(250);
    test_pause_drain();
    test_back_to_back();
    wait_drained();
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("svpwm_min_max_injection_test: done, clean");
    end else begin
      $display("svpwm_min_max_injection_test: done, errors");
    end
    $finish;
  end

endmodule
